// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: implication");

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// ----- rtl/core/stip_pkg.sv -----
// Types and constants of the string-to-integer parser.
package stip_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int OFFSET_WIDTH = 16;
    localparam int CHAR_WIDTH   = 8;
    localparam int BASE_WIDTH   = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b1;

    localparam logic [BASE_WIDTH-1:0] BASE_DETECT = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_WIDTH-1:0] DIGIT_NONE  = 6'd36;
    localparam logic [BASE_WIDTH-1:0] DIGIT_ALPHA = 6'd10;

    localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7a;

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

endpackage

// ----- rtl/core/string_to_integer_parser.sv -----
// Top level of the string-to-integer parser.
// Streams the bytes of a NUL-terminated string and, on the NUL, returns the
// parsed value (strtol/strtoul style: white space, sign, base prefix, digits
// wrapping modulo 2^32), the offset just past the number and a flag telling
// whether any digit was seen. One byte is taken every cycle, but for the time
// a NUL beat waits in the input register; the NUL beat passes through the input
// register, the single multiply-add by the radix and the result register before
// its result turns valid. A NUL beat waits in the input register only while the
// previous result is still unread. Write number_base and signed_mode only while
// no string is in flight.
module string_to_integer_parser
    import stip_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CHAR_WIDTH-1:0]   i_char_code,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VALUE_WIDTH-1:0]  o_parsed_value,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic                    o_any_digits
);

    function automatic logic [BASE_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] c);
        logic [BASE_WIDTH-1:0] v;
        v = DIGIT_NONE;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            v = BASE_WIDTH'(c - CH_ZERO);
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            v = BASE_WIDTH'(c - CH_LA) + DIGIT_ALPHA;
        end else if (c inside {[CH_UA:CH_UZ]}) begin
            v = BASE_WIDTH'(c - CH_UA) + DIGIT_ALPHA;
        end
        return v;
    endfunction

    function automatic logic [OFFSET_WIDTH-1:0] sat_add(input logic [OFFSET_WIDTH-1:0] a,
                                                        input logic [1:0] n);
        logic [OFFSET_WIDTH:0] s;
        s = {1'b0, a} + (OFFSET_WIDTH+1)'(n);
        return s[OFFSET_WIDTH] ? {OFFSET_WIDTH{1'b1}} : s[OFFSET_WIDTH-1:0];
    endfunction

    // configuration
    logic [BASE_WIDTH-1:0]   r_number_base;
    logic                    r_signed_mode;

    // input register
    logic                    r_in_vld;
    logic [CHAR_WIDTH-1:0]   r_in_char;

    // parse state
    t_phase                  r_phase, n_phase;
    logic [VALUE_WIDTH-1:0]  r_acc, n_acc;
    logic [BASE_WIDTH-1:0]   r_base, n_base;
    logic                    r_neg, n_neg;
    logic [OFFSET_WIDTH-1:0] r_end, n_end;
    logic                    r_seen, n_seen;

    // result register
    logic                    r_out_vld;
    logic [VALUE_WIDTH-1:0]  r_out_acc;
    logic                    r_out_neg;
    logic [OFFSET_WIDTH-1:0] r_out_end;
    logic                    r_out_seen;

    logic                    proc_fire;
    logic                    is_nul;
    logic                    first_after_sign;
    logic                    try_digit;
    logic                    digit_hit;
    logic [BASE_WIDTH-1:0]   dig_base;
    logic [BASE_WIDTH-1:0]   dig_val;
    logic [1:0]              pre_add;
    logic [1:0]              end_add;
    logic [VALUE_WIDTH-1:0]  prod;

    assign is_nul     = (r_in_char == CH_NUL);
    // a NUL beat waits only while the result register is occupied and not being read
    assign proc_fire  = r_in_vld && (!is_nul || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || proc_fire;

    always_comb begin
        n_phase          = r_phase;
        n_acc            = r_acc;
        n_base           = r_base;
        n_neg            = r_neg;
        n_seen           = r_seen;
        first_after_sign = 1'b0;
        try_digit        = 1'b0;
        dig_base         = r_base;
        pre_add          = 2'd0;
        dig_val          = digit_value(r_in_char);

        case (r_phase)
            PH_SPACE: begin
                if (r_in_char == CH_SPACE || r_in_char inside {[CH_TAB:CH_CR]}) begin
                    pre_add = 2'd1;
                end else if ((r_in_char == CH_MINUS && r_signed_mode) ||
                             r_in_char == CH_PLUS) begin
                    n_neg   = (r_in_char == CH_MINUS);
                    pre_add = 2'd1;
                    n_phase = PH_PREFIX;
                end else begin
                    first_after_sign = 1'b1;
                end
            end
            PH_PREFIX: begin
                first_after_sign = 1'b1;
            end
            PH_ZERO: begin
                n_phase = PH_DIGITS;
                if (r_in_char == CH_LX || r_in_char == CH_UX) begin
                    n_base  = BASE_HEX;
                    pre_add = 2'd2;
                end else if (r_base == BASE_DETECT) begin
                    // leading zero was the octal prefix
                    n_base    = BASE_OCT;
                    pre_add   = 2'd1;
                    try_digit = 1'b1;
                    dig_base  = BASE_OCT;
                end else begin
                    // hex with no x: the held zero counts as a digit
                    n_seen    = 1'b1;
                    pre_add   = 2'd1;
                    try_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                try_digit = 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (first_after_sign) begin
            if (r_in_char == CH_ZERO &&
                (r_number_base == BASE_DETECT || r_number_base == BASE_HEX)) begin
                n_base  = r_number_base;
                n_phase = PH_ZERO;
            end else begin
                dig_base  = (r_number_base == BASE_DETECT) ? BASE_DEC : r_number_base;
                n_base    = dig_base;
                n_phase   = PH_DIGITS;
                try_digit = 1'b1;
            end
        end

        prod      = r_acc * VALUE_WIDTH'(dig_base);
        digit_hit = try_digit && (dig_val < dig_base);
        if (digit_hit) begin
            n_acc  = prod + VALUE_WIDTH'(dig_val);
            n_seen = 1'b1;
        end else if (try_digit) begin
            n_phase = PH_DONE;
        end
        end_add = pre_add + {1'b0, digit_hit};
        n_end   = sat_add(r_end, end_add);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_DEC;
            r_signed_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_NUMBER_BASE: r_number_base <= i_cfg_data[BASE_WIDTH-1:0];
                CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_SPACE;
            r_acc     <= '0;
            r_base    <= '0;
            r_neg     <= 1'b0;
            r_end     <= '0;
            r_seen    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (proc_fire && is_nul) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (proc_fire) begin
                if (is_nul) begin
                    // rearm for the next string
                    r_phase <= PH_SPACE;
                    r_acc   <= '0;
                    r_base  <= '0;
                    r_neg   <= 1'b0;
                    r_end   <= '0;
                    r_seen  <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_acc   <= n_acc;
                    r_base  <= n_base;
                    r_neg   <= n_neg;
                    r_end   <= n_end;
                    r_seen  <= n_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_char_code;
        end
        if (proc_fire && is_nul) begin
            r_out_acc  <= n_acc;
            r_out_neg  <= n_neg;
            r_out_end  <= n_end;
            r_out_seen <= n_seen;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_parsed_value = r_out_neg ? (VALUE_WIDTH'(0) - r_out_acc) : r_out_acc;
    assign o_end_offset   = r_out_end;
    assign o_any_digits   = r_out_seen;

endmodule

// ----- rtl/core/stip_checker.sv -----
// Port-level checks of the string-to-integer parser, bound to the top level.
`include "assert_macros.svh"

module stip_checker
    import stip_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input logic [CFG_DATA_W-1:0]   i_cfg_data,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [CHAR_WIDTH-1:0]   i_char_code,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [VALUE_WIDTH-1:0]  o_parsed_value,
    input logic [OFFSET_WIDTH-1:0] o_end_offset,
    input logic                    o_any_digits
);

    logic nul_beat;
    logic cfg_touch;

    assign nul_beat  = i_in_valid && o_in_ready && (i_char_code == CH_NUL);
    assign cfg_touch = i_cfg_wr_en && (i_cfg_idx == CFG_NUMBER_BASE) && (i_cfg_data == '0);

    // hold a stalled result beat
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_parsed_value) && $stable(o_end_offset) && $stable(o_any_digits))
    // an empty result register never blocks input
    `CHK_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // a fresh result follows its NUL beat through the input and result registers
    `CHK_IMPL(a_result_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(nul_beat, 2))
    // no digits means no value
    `CHK_IMPL(a_no_digit_zero, i_clk, i_rst_n, o_out_valid && !o_any_digits && !cfg_touch, o_parsed_value == '0)

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (.*);

// ----- tb/parse_result_checker.sv -----
// Checker for the string-to-integer parser: predicts each result from the byte stream.
module parse_result_checker
    import stip_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [CHAR_WIDTH-1:0]   i_char_code,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [VALUE_WIDTH-1:0]  i_parsed_value,
    input  logic [OFFSET_WIDTH-1:0] i_end_offset,
    input  logic                    i_any_digits,
    output int                      o_mismatch_count,
    output int                      o_open_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  value;
        logic [OFFSET_WIDTH-1:0] offset;
        logic                    digits;
    } t_number;

    t_number queued_numbers[$];

    // configuration copy
    logic [BASE_WIDTH-1:0]   base_reg;
    logic                    signed_reg;

    // parse state
    t_phase                  phase_q;
    logic [VALUE_WIDTH-1:0]  acc_q;
    logic [BASE_WIDTH-1:0]   radix_q;
    logic                    neg_q;
    logic [OFFSET_WIDTH-1:0] end_pos_q;
    logic                    seen_q;

    initial begin
        o_mismatch_count = 0;
        o_open_results   = 0;
    end

    function automatic logic [OFFSET_WIDTH-1:0] offset_add(input logic [OFFSET_WIDTH-1:0] a,
                                                           input int n);
        longint s;
        s = longint'(a) + n;
        return (s > {OFFSET_WIDTH{1'b1}}) ? {OFFSET_WIDTH{1'b1}} : OFFSET_WIDTH'(s);
    endfunction

    function automatic logic [BASE_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return BASE_WIDTH'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ) return BASE_WIDTH'(c - CH_LA) + DIGIT_ALPHA;
        if (c >= CH_UA && c <= CH_UZ) return BASE_WIDTH'(c - CH_UA) + DIGIT_ALPHA;
        return DIGIT_NONE;
    endfunction

    function automatic void clear_parse();
        phase_q   = PH_SPACE;
        acc_q     = '0;
        radix_q   = '0;
        neg_q     = 1'b0;
        end_pos_q = '0;
        seen_q    = 1'b0;
    endfunction

    function automatic void accept_digit(input logic [CHAR_WIDTH-1:0] c);
        logic [BASE_WIDTH-1:0] d;
        d = digit_of(c);
        if (d < radix_q) begin
            acc_q     = acc_q * radix_q + d;
            seen_q    = 1'b1;
            end_pos_q = offset_add(end_pos_q, 1);
        end else begin
            phase_q = PH_DONE;
        end
    endfunction

    // First byte after any sign: pick the radix, holding a leading zero for later.
    function automatic void begin_number(input logic [CHAR_WIDTH-1:0] c);
        if (c == CH_ZERO && (base_reg == BASE_DETECT || base_reg == BASE_HEX)) begin
            radix_q = base_reg;
            phase_q = PH_ZERO;
        end else begin
            radix_q = (base_reg == BASE_DETECT) ? BASE_DEC : base_reg;
            phase_q = PH_DIGITS;
            accept_digit(c);
        end
    endfunction

    function automatic void resolve_zero(input logic [CHAR_WIDTH-1:0] c);
        phase_q = PH_DIGITS;
        if (c == CH_LX || c == CH_UX) begin
            radix_q   = BASE_HEX;
            end_pos_q = offset_add(end_pos_q, 2);
        end else begin
            if (radix_q == BASE_DETECT) begin
                radix_q   = BASE_OCT;
                end_pos_q = offset_add(end_pos_q, 1);
            end else begin
                accept_digit(CH_ZERO);
            end
            accept_digit(c);
        end
    endfunction

    function automatic void predict_byte(input logic [CHAR_WIDTH-1:0] c);
        t_number n;
        case (phase_q)
            PH_SPACE: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    end_pos_q = offset_add(end_pos_q, 1);
                end else if ((c == CH_MINUS && signed_reg) || c == CH_PLUS) begin
                    neg_q     = (c == CH_MINUS);
                    end_pos_q = offset_add(end_pos_q, 1);
                    phase_q   = PH_PREFIX;
                end else begin
                    begin_number(c);
                end
            end
            PH_PREFIX: begin_number(c);
            PH_ZERO:   resolve_zero(c);
            PH_DIGITS: accept_digit(c);
            default: ;
        endcase
        if (c == CH_NUL) begin
            n.value  = neg_q ? ('0 - acc_q) : acc_q;
            n.offset = end_pos_q;
            n.digits = seen_q;
            queued_numbers.push_back(n);
            clear_parse();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
                                   input logic [VALUE_WIDTH-1:0] want);
        $display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        o_mismatch_count++;
    endtask

    task automatic check_result();
        t_number want;
        if (queued_numbers.size() == 0) begin
            report_mismatch("result beat with no string ended", i_parsed_value, '0);
        end else begin
            want = queued_numbers.pop_front();
            if (i_parsed_value !== want.value)
                report_mismatch("parsed_value", i_parsed_value, want.value);
            if (i_end_offset !== want.offset)
                report_mismatch("end_offset", i_end_offset, want.offset);
            if (i_any_digits !== want.digits)
                report_mismatch("any_digits", i_any_digits, want.digits);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_reg   = BASE_DEC;
            signed_reg = 1'b1;
            clear_parse();
            queued_numbers.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_NUMBER_BASE) base_reg = i_cfg_data[BASE_WIDTH-1:0];
                else if (i_cfg_idx == CFG_SIGNED_MODE) signed_reg = i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready) predict_byte(i_char_code);
            if (i_out_valid && i_out_ready) check_result();
        end
        o_open_results <= queued_numbers.size();
    end

endmodule

// ----- tb/tb_string_to_integer_parser.sv -----
// Testbench top for the string-to-integer parser: stimulus, stalls and verdict.
module tb_string_to_integer_parser
    import stip_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PHASE_COUNT      = 12;
    localparam int PHASE_BYTES      = 135;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [CHAR_WIDTH-1:0]   i_char_code;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [VALUE_WIDTH-1:0]  o_parsed_value;
    logic [OFFSET_WIDTH-1:0] o_end_offset;
    logic                    o_any_digits;

    int                      mismatch_count;
    int                      open_results;
    int                      sender_pct;
    int                      stall_pct;
    bit                      long_hold;
    int                      quiet_cycles;
    logic [CHAR_WIDTH-1:0]   text_q[$];

    string_to_integer_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_parsed_value (o_parsed_value),
        .o_end_offset   (o_end_offset),
        .o_any_digits   (o_any_digits)
    );

    parse_result_checker result_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_char_code      (i_char_code),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_parsed_value   (o_parsed_value),
        .i_end_offset     (o_end_offset),
        .i_any_digits     (o_any_digits),
        .o_mismatch_count (mismatch_count),
        .o_open_results   (open_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Abort when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [CHAR_WIDTH-1:0] c);
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_text();
        int gap;
        foreach (text_q[k]) begin
            push_char(text_q[k]);
            gap = 0;
            while (sender_pct != 0 && $urandom_range(99) < sender_pct) gap++;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        text_q.delete();
    endtask

    // Drop valid and hold until every ended string has produced its result.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (open_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [BASE_WIDTH-1:0] base, input logic sgn);
        logic [CFG_DATA_W-2:0] filler;
        wait_idle();
        filler = ($urandom_range(1) == 0) ? '0 : (CFG_DATA_W-1)'($urandom);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_NUMBER_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SIGNED_MODE;
        i_cfg_data  <= {filler, sgn};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
        text_q.push_back(CH_NUL);
    endtask

    // One NUL-terminated string: mostly a well-formed number, sometimes noise.
    task automatic add_random_number(input logic [BASE_WIDTH-1:0] base);
        int                    n_dig;
        logic [BASE_WIDTH-1:0] radix;
        logic [BASE_WIDTH-1:0] span;
        logic [BASE_WIDTH-1:0] v;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(0, 8)) text_q.push_back(CHAR_WIDTH'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3))
                    text_q.push_back(($urandom_range(1) == 0) ? CH_SPACE
                                     : CHAR_WIDTH'($urandom_range(CH_TAB, CH_CR)));
            end
            case ($urandom_range(3))
                0: text_q.push_back(CH_PLUS);
                1: text_q.push_back(CH_MINUS);
                default: ;
            endcase
            radix = (base == BASE_DETECT) ? BASE_DEC : base;
            if ((base == BASE_DETECT || base == BASE_HEX) && $urandom_range(2) == 0) begin
                text_q.push_back(CH_ZERO);
                if ($urandom_range(3) != 0) begin
                    text_q.push_back(($urandom_range(1) == 0) ? CH_LX : CH_UX);
                    radix = BASE_HEX;
                end else if (base == BASE_DETECT) begin
                    radix = BASE_OCT;
                end
            end
            span  = (radix > DIGIT_NONE) ? DIGIT_NONE : radix;
            n_dig = ($urandom_range(3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
            repeat (n_dig) begin
                v = BASE_WIDTH'($urandom_range(span - 1));
                if (v < DIGIT_ALPHA)
                    text_q.push_back(CHAR_WIDTH'(CH_ZERO + v));
                else
                    text_q.push_back(CHAR_WIDTH'((($urandom_range(1) == 0) ? CH_LA : CH_UA)
                                                 + v - DIGIT_ALPHA));
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3))
                    text_q.push_back(CHAR_WIDTH'($urandom_range(1, 255)));
        end
        text_q.push_back(CH_NUL);
    endtask

    initial begin
        logic [BASE_WIDTH-1:0] plan_base [PHASE_COUNT];
        int phase_bytes;
        plan_base = '{6'd0, 6'd16, 6'd10, 6'd8, 6'd1,
            6'd36, 6'd0, 6'd63, 6'd37, 6'd16, 6'd2, 6'd0};
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_idx   <= CFG_NUMBER_BASE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_char_code <= CH_NUL;
        sender_pct  = 0;
        stall_pct   = 0;
        long_hold   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset setting: decimal, signed.
        add_text(" \t-12");
        add_text("+");
        send_text();
        // Detect mode: lone zero, bare hex prefix.
        apply_setting(BASE_DETECT, 1'b1);
        add_text("0");
        add_text("0x");
        send_text();
        apply_setting(BASE_HEX, 1'b0);
        add_text("0XfF");
        send_text();
        apply_setting(6'd1, 1'b0);
        add_text("01");
        send_text();
        // Minus is no sign in unsigned mode.
        apply_setting(6'd36, 1'b0);
        add_text("-z");
        send_text();
        apply_setting(6'd63, 1'b1);
        text_q.push_back(8'hff);
        text_q.push_back(CH_NUL);
        send_text();

        plan_base[10] = BASE_WIDTH'($urandom_range(63));
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            apply_setting(plan_base[ph], (ph < 2) ? ph[0] : 1'($urandom_range(1)));
            case (ph % 4)
                0: begin sender_pct = 0;  stall_pct = 0;  end
                1: begin sender_pct = 77; stall_pct = 0;  end
                2: begin sender_pct = 0;  stall_pct = 77; end
                default: begin sender_pct = 20; stall_pct = 20; end
            endcase
            // Stall the output long enough for the input to back up.
            if (ph == 2) long_hold = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                add_random_number(plan_base[ph]);
                phase_bytes += text_q.size();
                send_text();
            end
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
